@@ hw/rtl/ppas_pkg.sv @@
// Shared types, constants and helpers for the point-in-polygon angle sum unit.
package ppas_pkg;

  localparam int ACC_W    = 24;
  localparam int SUM_W    = ACC_W + 1;
  localparam int TOL_W    = 13;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;
  localparam int ATAN_LEN = 24;

  localparam logic [TOL_W-1:0] TOL_RESET = 13'd1043;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // atan(2^-i) as a fraction of a full turn, scaled to 2^32
  localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic first;
    logic last;
  } flags_t;

  // Clamp a one-bit-grown sum back to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] s);
    logic signed [ACC_W-1:0] r;
    if (s[SUM_W-1] != s[SUM_W-2]) begin
      r = s[SUM_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ppas_channels.sv @@
// Handshake channel interfaces: vertex input, result output, tolerance write.
interface ppas_in_if #(parameter int COORD_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          first_vertex;
  logic                          last_vertex;
  logic signed [COORD_BITS-1:0]  vertex_x;
  logic signed [COORD_BITS-1:0]  vertex_y;
  logic signed [COORD_BITS-1:0]  query_x;
  logic signed [COORD_BITS-1:0]  query_y;

  modport source (output valid, first_vertex, last_vertex, vertex_x, vertex_y,
                  query_x, query_y, input ready);
  modport sink   (input valid, first_vertex, last_vertex, vertex_x, vertex_y,
                  query_x, query_y, output ready);
endinterface

interface ppas_out_if;
  import ppas_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     inside_res;
  logic                     polygon_valid;
  logic signed [ACC_W-1:0]  total_angle;

  modport source (output valid, inside_res, polygon_valid, total_angle, input ready);
  modport sink   (input valid, inside_res, polygon_valid, total_angle, output ready);
endinterface

interface ppas_cfg_if;
  import ppas_pkg::*;
  logic              valid;
  logic              ready;
  logic [TOL_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/point_in_polygon_angle_sum_unit.sv @@
// Point-in-polygon angle sum unit: one vertex per cycle unless stalled, result on each last vertex.
// Path: a last vertex passes the difference register, the CORDIC input register and
// pipeline, the queue and the three back stages before its result is offered.
// Throughput: one vertex per cycle; the front stalls only while the 4-entry queue is full.
// Reset: clears the held point, angles, accumulator, tally and all valid flags;
// the tolerance register returns to 1043.
module point_in_polygon_angle_sum_unit #(
  parameter int COORD_BITS    = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ppas_in_if.sink     in_ch,
  ppas_out_if.source  out_ch,
  ppas_cfg_if.sink    cfg_ch
);
  import ppas_pkg::*;

  localparam int FL_W   = $bits(flags_t);
  localparam int DATA_W = ANGLE_BITS + FL_W;

  logic [TOL_W-1:0]       tol_r;
  logic                   push_v;
  flags_t                 push_flags;
  logic [ANGLE_BITS-1:0]  push_angle;
  logic [DATA_W-1:0]      pop_data;
  logic                   q_nonempty, q_full, q_pop;
  flags_t                 q_flags;
  logic [ANGLE_BITS-1:0]  q_angle;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_ch.valid) begin
      tol_r <= cfg_ch.data;
    end
  end

  ppas_front #(
    .COORD_BITS    (COORD_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .stall      (q_full),
    .push_v     (push_v),
    .push_flags (push_flags),
    .push_angle (push_angle)
  );

  ppas_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_v),
    .push_data ({push_flags, push_angle}),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .nonempty  (q_nonempty),
    .full      (q_full)
  );

  assign q_flags = flags_t'(pop_data[DATA_W-1 -: FL_W]);
  assign q_angle = pop_data[ANGLE_BITS-1:0];

  ppas_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_nonempty),
    .q_flags (q_flags),
    .q_angle (q_angle),
    .pop     (q_pop),
    .tol     (tol_r),
    .out_ch  (out_ch)
  );

endmodule

@@ hw/rtl/ppas_front.sv @@
// Front end: query point hold, vertex difference and pipelined CORDIC atan2.
module ppas_front #(
  parameter int COORD_BITS    = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ppas_in_if.sink                in_ch,
  input  logic                   stall,
  output logic                   push_v,
  output ppas_pkg::flags_t       push_flags,
  output logic [ANGLE_BITS-1:0]  push_angle
);
  import ppas_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int W  = COORD_BITS + 3;
  localparam int N  = CORDIC_STAGES;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic adv;
  logic take;
  logic signed [COORD_BITS-1:0] held_x_r, held_y_r;
  logic signed [COORD_BITS-1:0] src_x, src_y;

  logic                  d_v_r;
  flags_t                d_flags_r;
  logic signed [DW-1:0]  dx_r, dy_r;

  logic signed [W-1:0]   dxe, dye;
  logic signed [W-1:0]   pre_x, pre_y;
  logic [ANGLE_BITS-1:0] pre_z;

  logic                  v_r     [N+1];
  logic                  zero_r  [N+1];
  flags_t                flags_r [N+1];
  logic signed [W-1:0]   x_r     [N+1];
  logic signed [W-1:0]   y_r     [N+1];
  logic [ANGLE_BITS-1:0] z_r     [N+1];

  // whole pipeline moves together; hold everything while the queue is full
  assign adv         = !stall;
  assign in_ch.ready = adv;
  assign take        = in_ch.valid && adv;

  assign src_x = in_ch.first_vertex ? in_ch.query_x : held_x_r;
  assign src_y = in_ch.first_vertex ? in_ch.query_y : held_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r    <= 1'b0;
      held_x_r <= '0;
      held_y_r <= '0;
    end else if (adv) begin
      d_v_r <= take;
      if (take && in_ch.first_vertex) begin
        held_x_r <= in_ch.query_x;
        held_y_r <= in_ch.query_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_flags_r <= '{first: in_ch.first_vertex, last: in_ch.last_vertex};
      dx_r      <= {in_ch.vertex_x[COORD_BITS-1], in_ch.vertex_x} -
                   {src_x[COORD_BITS-1], src_x};
      dy_r      <= {in_ch.vertex_y[COORD_BITS-1], in_ch.vertex_y} -
                   {src_y[COORD_BITS-1], src_y};
    end
  end

  // fold the left half plane onto the right one
  assign dxe = {{(W-DW){dx_r[DW-1]}}, dx_r};
  assign dye = {{(W-DW){dy_r[DW-1]}}, dy_r};

  always_comb begin
    if (dx_r[DW-1]) begin
      pre_x = -dxe;
      pre_y = -dye;
      pre_z = HALF_TURN;
    end else begin
      pre_x = dxe;
      pre_y = dye;
      pre_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r[0]  <= (dx_r == '0) && (dy_r == '0);
      flags_r[0] <= d_flags_r;
      x_r[0]     <= pre_x;
      y_r[0]     <= pre_y;
      z_r[0]     <= pre_z;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [32:0] STEP_FULL = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
    localparam logic [ANGLE_BITS-1:0] STEP = STEP_FULL[32-ANGLE_BITS +: ANGLE_BITS];

    logic signed [W-1:0]   xs, ys;
    logic signed [W-1:0]   x_nxt, y_nxt;
    logic [ANGLE_BITS-1:0] z_nxt;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_comb begin
      if (!y_r[i][W-1]) begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + STEP;
      end else begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - STEP;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        zero_r[i+1]  <= zero_r[i];
        flags_r[i+1] <= flags_r[i];
        x_r[i+1]     <= x_nxt;
        y_r[i+1]     <= y_nxt;
        z_r[i+1]     <= z_nxt;
      end
    end
  end

  assign push_v     = v_r[N] && adv;
  assign push_flags = flags_r[N];
  assign push_angle = zero_r[N] ? '0 : z_r[N];

endmodule

@@ hw/rtl/ppas_queue.sv @@
// Short FIFO between the angle front end and the accumulating back end.
module ppas_queue #(
  parameter int DATA_W = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [DATA_W-1:0]  push_data,
  input  logic               pop,
  output logic [DATA_W-1:0]  pop_data,
  output logic               nonempty,
  output logic               full
);
  import ppas_pkg::*;

  logic [DATA_W-1:0] mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r, count_nxt;

  assign nonempty = (count_r != '0);
  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/ppas_back.sv @@
// Back end: wrapped angle-difference accumulation, closing sum and inside test.
module ppas_back #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  ppas_pkg::flags_t               q_flags,
  input  logic [ANGLE_BITS-1:0]          q_angle,
  output logic                           pop,
  input  logic [ppas_pkg::TOL_W-1:0]     tol,
  ppas_out_if.source                     out_ch
);
  import ppas_pkg::*;

  localparam int BND_W = ((ANGLE_BITS > ACC_W - 1) ? ANGLE_BITS : ACC_W - 1) + 3;
  localparam logic signed [BND_W-1:0] TURN = BND_W'(1) << ANGLE_BITS;

  // running polygon state
  logic [ANGLE_BITS-1:0]    opening_r, opening_nxt;
  logic [ANGLE_BITS-1:0]    prev_r, prev_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [1:0]               tally_r, tally_nxt;

  logic                          open_new;
  logic signed [ANGLE_BITS-1:0]  d1, d2;
  logic [ANGLE_BITS-1:0]         open_upd;
  logic signed [ACC_W-1:0]       acc_upd;
  logic [1:0]                    tally_upd;

  // closing stage, check stage, output register
  logic                          b_v_r, b_poly_r;
  logic signed [ACC_W-1:0]       b_acc_r;
  logic signed [ANGLE_BITS-1:0]  b_d2_r;
  logic                          c_v_r, c_poly_r;
  logic signed [ACC_W-1:0]       c_total_r;
  logic                          out_v_r, out_inside_r, out_poly_r;
  logic signed [ACC_W-1:0]       out_total_r;

  logic                     out_adv, c_adv, b_adv;
  logic signed [ACC_W-1:0]  total;
  logic signed [BND_W-1:0]  tol_e, c_total_e;
  logic signed [BND_W-1:0]  pos_lo_r, pos_hi_r, neg_lo_r, neg_hi_r;
  logic                     in_window;

  assign out_adv = !out_v_r || out_ch.ready;
  assign c_adv   = !c_v_r || out_adv;
  assign b_adv   = !b_v_r || c_adv;
  assign pop     = q_valid && b_adv;

  // open a polygon on a first vertex or when none is open
  assign open_new  = q_flags.first || (tally_r == 2'd0);
  assign d1        = q_angle - prev_r;
  assign acc_upd   = open_new ? '0 : sat_acc(SUM_W'(acc_r) + SUM_W'(d1));
  assign tally_upd = open_new ? 2'd1 : ((tally_r == 2'd3) ? 2'd3 : tally_r + 2'd1);
  assign open_upd  = open_new ? q_angle : opening_r;
  assign d2        = open_upd - q_angle;

  always_comb begin
    opening_nxt = opening_r;
    prev_nxt    = prev_r;
    acc_nxt     = acc_r;
    tally_nxt   = tally_r;
    if (pop) begin
      opening_nxt = open_upd;
      prev_nxt    = q_angle;
      if (q_flags.last) begin
        acc_nxt   = '0;
        tally_nxt = 2'd0;
      end else begin
        acc_nxt   = acc_upd;
        tally_nxt = tally_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opening_r <= '0;
      prev_r    <= '0;
      acc_r     <= '0;
      tally_r   <= 2'd0;
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      opening_r <= opening_nxt;
      prev_r    <= prev_nxt;
      acc_r     <= acc_nxt;
      tally_r   <= tally_nxt;
      if (b_adv) begin
        b_v_r <= pop && q_flags.last;
      end
      if (c_adv) begin
        c_v_r <= b_v_r;
      end
      if (out_adv) begin
        out_v_r <= c_v_r;
      end
    end
  end

  assign total = sat_acc(SUM_W'(b_acc_r) + SUM_W'(b_d2_r));

  // window bounds follow the tolerance register
  assign tol_e = BND_W'(tol);

  always_ff @(posedge clk) begin
    pos_lo_r <= TURN - tol_e;
    pos_hi_r <= TURN + tol_e;
    neg_lo_r <= -TURN - tol_e;
    neg_hi_r <= -TURN + tol_e;
  end

  assign c_total_e = BND_W'(c_total_r);
  assign in_window = c_poly_r &&
                     (((c_total_e > pos_lo_r) && (c_total_e < pos_hi_r)) ||
                      ((c_total_e > neg_lo_r) && (c_total_e < neg_hi_r)));

  always_ff @(posedge clk) begin
    if (b_adv) begin
      b_acc_r  <= acc_upd;
      b_d2_r   <= d2;
      b_poly_r <= (tally_upd == 2'd3);
    end
    if (c_adv) begin
      c_total_r <= total;
      c_poly_r  <= b_poly_r;
    end
    if (out_adv) begin
      out_total_r  <= c_total_r;
      out_poly_r   <= c_poly_r;
      out_inside_r <= in_window;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.inside_res    = out_inside_r;
  assign out_ch.polygon_valid = out_poly_r;
  assign out_ch.total_angle   = out_total_r;

endmodule
